FILE: hdl/qrm_pkg.sv
// Shared types and fixed-point constants for the quaternion to rotation matrix block.
`timescale 1ns / 1ps
package qrm_pkg;

  // 20.12 signed fixed point
  localparam int FX_W     = 32;
  localparam int FX_SHIFT = 12;
  localparam int PROD_W   = 2 * FX_W;

  typedef logic signed [FX_W-1:0]   fx_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam fx_t   FX_ONE  = fx_t'(32'h0000_1000);
  localparam prod_t FX_HALF = prod_t'(64'h0000_0000_0000_0800);

endpackage

FILE: hdl/quat_to_rotation_matrix_fx_core.sv
// Top level: quaternion (20.12) to 3x3 rotation matrix (20.12), four-stage pipeline.
`timescale 1ns / 1ps
// Usage
//   Input channel: in_valid / in_stall with the quaternion in_quat_w .. in_quat_z.
//   Result channel: out_valid / out_stall with the nine elements out_elem_00 .. 22.
//   An item is taken at a clock edge where valid is high and stall is low.
// Timing
//   One item per cycle sustained when the receiver does not stall. A result
//   passes the operand register, multiply register, round register and
//   output register in order after its item is taken.
//   Stage depth is set by the 32x32 multipliers, one per register stage,
//   with rounding and the final add/subtract each in a stage of their own.
// Stall
//   The whole pipeline holds while a result waits under out_stall; in_stall
//   is raised in the same cycle so no item is lost or repeated. Empty stages
//   do not advance on their own, so bubbles stay in place during a stall.
// Reset
//   rst_n (synchronous, active low) clears all valid bits; no item is in
//   flight afterwards. Data registers are not reset.
module quat_to_rotation_matrix_fx_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  qrm_pkg::fx_t in_quat_w,
  input  qrm_pkg::fx_t in_quat_x,
  input  qrm_pkg::fx_t in_quat_y,
  input  qrm_pkg::fx_t in_quat_z,
  output logic         out_valid,
  input  logic         out_stall,
  output qrm_pkg::fx_t out_elem_00,
  output qrm_pkg::fx_t out_elem_01,
  output qrm_pkg::fx_t out_elem_02,
  output qrm_pkg::fx_t out_elem_10,
  output qrm_pkg::fx_t out_elem_11,
  output qrm_pkg::fx_t out_elem_12,
  output qrm_pkg::fx_t out_elem_20,
  output qrm_pkg::fx_t out_elem_21,
  output qrm_pkg::fx_t out_elem_22
);
  import qrm_pkg::*;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r;

  fx_t w_r, x_r, y_r, z_r, x2_r, y2_r, z2_r;

  fx_t wx, wy, wz, xx, xy, xz, yy, yz, zz;

  fx_t e00_r, e01_r, e02_r, e10_r, e11_r, e12_r, e20_r, e21_r, e22_r;

  // pipeline moves unless a finished item is held at the output
  assign adv      = !(v4_r && out_stall);
  assign in_stall = !adv;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage 1: operands and doubled vector parts (32-bit wrap)
  always_ff @(posedge clk) begin
    if (adv) begin
      w_r  <= in_quat_w;
      x_r  <= in_quat_x;
      y_r  <= in_quat_y;
      z_r  <= in_quat_z;
      x2_r <= in_quat_x <<< 1;
      y2_r <= in_quat_y <<< 1;
      z2_r <= in_quat_z <<< 1;
    end
  end

  // stages 2 and 3: nine products, then rounding
  qrm_prod u_wx (.clk(clk), .adv(adv), .op_a(x2_r), .op_b(w_r), .rnd(wx));
  qrm_prod u_wy (.clk(clk), .adv(adv), .op_a(y2_r), .op_b(w_r), .rnd(wy));
  qrm_prod u_wz (.clk(clk), .adv(adv), .op_a(z2_r), .op_b(w_r), .rnd(wz));
  qrm_prod u_xx (.clk(clk), .adv(adv), .op_a(x2_r), .op_b(x_r), .rnd(xx));
  qrm_prod u_xy (.clk(clk), .adv(adv), .op_a(y2_r), .op_b(x_r), .rnd(xy));
  qrm_prod u_xz (.clk(clk), .adv(adv), .op_a(z2_r), .op_b(x_r), .rnd(xz));
  qrm_prod u_yy (.clk(clk), .adv(adv), .op_a(y2_r), .op_b(y_r), .rnd(yy));
  qrm_prod u_yz (.clk(clk), .adv(adv), .op_a(z2_r), .op_b(y_r), .rnd(yz));
  qrm_prod u_zz (.clk(clk), .adv(adv), .op_a(z2_r), .op_b(z_r), .rnd(zz));

  // stage 4: matrix elements, all sums wrap at 32 bits
  always_ff @(posedge clk) begin
    if (adv) begin
      e00_r <= FX_ONE - (yy + zz);
      e01_r <= xy + wz;
      e02_r <= xz - wy;
      e10_r <= xy - wz;
      e11_r <= FX_ONE - (xx + zz);
      e12_r <= yz + wx;
      e20_r <= xz + wy;
      e21_r <= yz - wx;
      e22_r <= FX_ONE - (xx + yy);
    end
  end

  assign out_valid   = v4_r;
  assign out_elem_00 = e00_r;
  assign out_elem_01 = e01_r;
  assign out_elem_02 = e02_r;
  assign out_elem_10 = e10_r;
  assign out_elem_11 = e11_r;
  assign out_elem_12 = e12_r;
  assign out_elem_20 = e20_r;
  assign out_elem_21 = e21_r;
  assign out_elem_22 = e22_r;

  // an accepted item reaches the output once the pipeline has advanced through every stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 adv ##1 adv ##1 adv |=> out_valid)
    else $error("accepted item did not reach the output in time");

  // the identity quaternion gives ones on the diagonal and zeros in elements 01, 12 and 20
  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_quat_w == FX_ONE && in_quat_x == '0
     && in_quat_y == '0 && in_quat_z == '0) ##1 adv ##1 adv ##1 adv
    |=> (out_elem_00 == FX_ONE && out_elem_11 == FX_ONE && out_elem_22 == FX_ONE
         && out_elem_01 == '0 && out_elem_12 == '0 && out_elem_20 == '0))
    else $error("identity quaternion gave a wrong matrix");

  // a stall freezes the valid bits of stages 1 to 3
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable({v1_r, v2_r, v3_r}))
    else $error("pipeline moved while stalled");

endmodule

FILE: hdl/qrm_prod.sv
// One rounded 20.12 product: a registered multiply followed by a registered round.
`timescale 1ns / 1ps
module qrm_prod (
  input  logic         clk,
  input  logic         adv,
  input  qrm_pkg::fx_t op_a,
  input  qrm_pkg::fx_t op_b,
  output qrm_pkg::fx_t rnd
);
  import qrm_pkg::*;

  prod_t prod_r;
  prod_t prod_nxt;
  prod_t sum_rnd;
  fx_t   rnd_r;
  fx_t   rnd_nxt;

  // full 64-bit signed product, operands sign-extended first
  assign prod_nxt = prod_t'(op_a) * prod_t'(op_b);

  // round half up, keep the low 32 bits of the shifted value
  assign sum_rnd = prod_r + FX_HALF;
  assign rnd_nxt = sum_rnd[FX_SHIFT +: FX_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      rnd_r  <= rnd_nxt;
    end
  end

  assign rnd = rnd_r;

endmodule

FILE: sim/tb_quat_to_rotation_matrix_fx_core.sv
// Self-checking testbench for the quaternion to rotation matrix core, with random idling on both sides.
`timescale 1ns / 1ps
module tb_quat_to_rotation_matrix_fx_core;
  import qrm_pkg::*;

  localparam int RANDOM_QUATS  = 1650;
  localparam int QUIET_LIMIT   = 1000;
  localparam int DRAIN_CYCLES  = 12;

  // nine elements, index 3*row+col
  typedef logic [8:0][FX_W-1:0] rot_mat_t;

  // Predicts each matrix and checks results in order
  class rotation_scoreboard;
    rot_mat_t pending_q[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // rounded 20.12 product, low 32 bits kept
    function fx_t round_product(fx_t a, fx_t b);
      longint p;
      p = longint'(a) * longint'(b) + longint'(FX_HALF);
      return fx_t'(p >>> FX_SHIFT);
    endfunction

    function rot_mat_t rotation_of(fx_t w, fx_t x, fx_t y, fx_t z);
      fx_t      x2, y2, z2;
      fx_t      wx, wy, wz, xx, xy, xz, yy, yz, zz;
      rot_mat_t m;
      // doubling wraps at 32 bits
      x2 = fx_t'(x << 1);
      y2 = fx_t'(y << 1);
      z2 = fx_t'(z << 1);
      wx = round_product(x2, w);
      wy = round_product(y2, w);
      wz = round_product(z2, w);
      xx = round_product(x2, x);
      xy = round_product(y2, x);
      xz = round_product(z2, x);
      yy = round_product(y2, y);
      yz = round_product(z2, y);
      zz = round_product(z2, z);
      m[0] = FX_ONE - fx_t'(yy + zz);
      m[1] = xy + wz;
      m[2] = xz - wy;
      m[3] = xy - wz;
      m[4] = FX_ONE - fx_t'(xx + zz);
      m[5] = yz + wx;
      m[6] = xz + wy;
      m[7] = yz - wx;
      m[8] = FX_ONE - fx_t'(xx + yy);
      return m;
    endfunction

    function void note_quat(fx_t w, fx_t x, fx_t y, fx_t z);
      pending_q.push_back(rotation_of(w, x, y, z));
    endfunction

    function void check_matrix(rot_mat_t got);
      rot_mat_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: matrix arrived with none pending, got %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      for (int i = 0; i < 9; i++) begin
        if (want[i] !== got[i]) begin
          $display("%0t: elem_%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                   want[i], got[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_stall = 1'b0;
  fx_t  in_quat_w = '0;
  fx_t  in_quat_x = '0;
  fx_t  in_quat_y = '0;
  fx_t  in_quat_z = '0;
  logic in_stall;
  logic out_valid;
  fx_t  out_elem_00, out_elem_01, out_elem_02;
  fx_t  out_elem_10, out_elem_11, out_elem_12;
  fx_t  out_elem_20, out_elem_21, out_elem_22;

  rotation_scoreboard rot_sb = new();
  int idle_pct  = 6;
  int stall_pct = 6;
  int quiet_cycles = 0;

  quat_to_rotation_matrix_fx_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_quat_w  (in_quat_w),
    .in_quat_x  (in_quat_x),
    .in_quat_y  (in_quat_y),
    .in_quat_z  (in_quat_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_elem_00(out_elem_00),
    .out_elem_01(out_elem_01),
    .out_elem_02(out_elem_02),
    .out_elem_10(out_elem_10),
    .out_elem_11(out_elem_11),
    .out_elem_12(out_elem_12),
    .out_elem_20(out_elem_20),
    .out_elem_21(out_elem_21),
    .out_elem_22(out_elem_22)
  );

  always #5 clk = ~clk;

  // Receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      rot_sb.check_matrix({out_elem_22, out_elem_21, out_elem_20,
                           out_elem_12, out_elem_11, out_elem_10,
                           out_elem_02, out_elem_01, out_elem_00});
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one quaternion, with random idle cycles ahead of it
  task automatic send_quat(fx_t w, fx_t x, fx_t y, fx_t z);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_quat_w <= w;
    in_quat_x <= x;
    in_quat_y <= y;
    in_quat_z <= z;
    do @(posedge clk); while (in_stall);
    rot_sb.note_quat(w, x, y, z);
  endtask

  // Mix of full-range, unit-scale, mid-range and corner components
  function automatic fx_t pick_component();
    fx_t corners [10] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h4000_0000, 32'hC000_0000, 32'h0000_1000, 32'hFFFF_F000,
                          32'h0000_0B50};
    case ($urandom_range(3))
      0: return fx_t'($urandom);
      1: return fx_t'(int'($urandom_range(8192)) - 4096);
      2: return fx_t'(int'($urandom_range(32'h0020_0000)) - 32'h0010_0000);
      default: return corners[$urandom_range(9)];
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, identity, axis rotations, 90 degree turns
    send_quat(32'h0, 32'h0, 32'h0, 32'h0);
    send_quat(FX_ONE, 32'h0, 32'h0, 32'h0);
    send_quat(32'h0, FX_ONE, 32'h0, 32'h0);
    send_quat(32'h0, 32'h0, FX_ONE, 32'h0);
    send_quat(32'h0, 32'h0, 32'h0, FX_ONE);
    send_quat(32'h0B50, 32'h0B50, 32'h0, 32'h0);
    send_quat(32'h0B50, 32'h0, 32'hFFFF_F4B0, 32'h0);
    send_quat(32'h0800, 32'h0800, 32'h0800, 32'h0800);
    // non-unit quaternion, used as it stands
    send_quat(32'h2000, 32'h3000, 32'hFFFF_B000, 32'h5000);
    // rounding edges: just at and just under one half LSB
    send_quat(32'h0, 32'h20, 32'h1F, 32'h0);
    send_quat(32'hFFFF_FFFF, 32'h400, 32'h3FF, 32'h401);
    // extremes of the fields
    send_quat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_quat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_quat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_quat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    // doubling wrap on x, y and z
    send_quat(FX_ONE, 32'h4000_0000, 32'hC000_0000, 32'h6000_0001);
    send_quat(32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000, 32'hBFFF_FFFF);
    // product and sum wrap
    send_quat(32'h0100_0000, 32'h0100_0000, 32'hFF00_0000, 32'h00FF_FFFF);
    send_quat(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC);

    // Random part, with a stretch where neither side idles
    for (int n = 0; n < RANDOM_QUATS; n++) begin
      if (n == 600) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else if (n == 900) begin
        idle_pct  = 6;
        stall_pct = 6;
      end
      send_quat(pick_component(), pick_component(), pick_component(), pick_component());
    end
    in_valid <= 1'b0;

    // Drain, then allow for any stray results
    while (rot_sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (rot_sb.errors == 0 && rot_sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
